### hdl/tcce_pkg.sv
package tcce_pkg;

  // request kinds carried in tuser
  typedef enum logic [1:0] {
    REQ_PUT   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_LOAD  = 2'd2,
    REQ_READ  = 2'd3
  } req_e;

  // control characters
  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_BS  = 8'h08;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;

  // space glyph, also the lowest printable code
  localparam logic [7:0] GLYPH_SPACE = 8'h20;

  localparam logic [7:0]  ATTR_RESET  = 8'h1F;
  localparam logic [15:0] CELL_RESET  = {ATTR_RESET, GLYPH_SPACE};
  localparam logic [2:0]  TAB_STEP    = 3'd4;
  localparam int          GLYPH_DEPTH = 256;

endpackage

### hdl/tcce_ram.sv
module tcce_ram #(
  parameter int Width = 16,
  parameter int Depth = 2000,
  localparam int AW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hdl/text_console_cursor_engine_top.sv
// Text-mode teletype: a screen store of COLUMNS*ROWS 16-bit cells (attribute in the
// high byte, glyph in the low byte), a cursor and a 256-entry glyph translation table.
// Each input item gives exactly one result item holding the cursor after the item, the
// cell read for a read request (zero otherwise, and zero for an address beyond the
// screen) and a flag set when the item scrolled the screen. Both stores sit in
// single-write, single-read RAMs with a registered read port; one item is worked at a
// time. For a put-character, load-translation or read-cell item the accept cycle
// launches the table or cell read; the next cycle does the write, if any, and
// delivers the result, or holds it while the output register is busy. Clear screen
// walks every cell, one write a cycle; a put-character item that runs off the end
// of the screen adds a scroll pass that copies each cell up one line through the
// RAM read port and blanks the last line. After reset a clearing pass loads blank
// cells and the identity glyph table; no item is taken meanwhile, but the attribute
// register can be written at any time.
// The attribute must only be written while the block is idle.
module text_console_cursor_engine_top
  import tcce_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // attribute register write
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // request items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // char_code[7:0], glyph_value[15:8], cell_index[26:16]
  input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // cursor_pos[10:0], read_data[26:11], scrolled[27]
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CURW  = $clog2(CELLS);
  localparam int COLW  = $clog2(COLUMNS);
  // sweep pointer must reach the last scroll step and cover the glyph table at reset
  localparam int SWMAX = (CELLS > GLYPH_DEPTH) ? CELLS : GLYPH_DEPTH;
  localparam int PW    = $clog2(SWMAX + 1);

  localparam logic [CURW:0]   COLS_X    = (CURW+1)'(COLUMNS);
  localparam logic [CURW:0]   CELLS_X   = (CURW+1)'(CELLS);
  localparam logic [CURW-1:0] LAST_ROW  = CURW'(CELLS - COLUMNS);
  localparam logic [COLW-1:0] LAST_COL  = COLW'(COLUMNS - 1);
  localparam logic [COLW:0]   COLS_C    = (COLW+1)'(COLUMNS);
  localparam logic [PW-1:0]   P_CELLS   = PW'(CELLS);
  localparam logic [PW-1:0]   P_LASTC   = PW'(CELLS - 1);
  localparam logic [PW-1:0]   P_BLANK   = PW'(CELLS - COLUMNS + 1);
  localparam logic [PW-1:0]   P_INITEND = PW'(SWMAX - 1);
  localparam logic [PW-1:0]   P_GLYPHS  = PW'(GLYPH_DEPTH);
  localparam logic [PW:0]     SRC_LIM   = (PW+1)'(CELLS);
  localparam logic [PW:0]     SRC_OFS   = (PW+1)'(COLUMNS);
  localparam logic [15:0]     IDX_LIM   = 16'(CELLS);

  // sequencer states
  localparam logic [2:0] ST_INIT   = 3'd0;  // reset clearing pass
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_EXEC   = 3'd2;  // read data back, write, update cursor
  localparam logic [2:0] ST_SCROLL = 3'd3;
  localparam logic [2:0] ST_CLEAR  = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;  // result waits for output register

  logic [2:0]      state_q, state_d;
  logic [PW-1:0]   ptr_q, ptr_d;
  logic [CURW-1:0] cursor_q, cursor_d;
  logic [CURW-1:0] base_q, base_d;        // first cell of the cursor's line
  logic [COLW-1:0] col_q, col_d;          // cursor column
  logic [7:0]      attr_q;

  // item latched at accept
  req_e            req_q;
  logic [7:0]      code_q;
  logic [7:0]      glyph_q;
  logic            inrange_q;

  // held result while the output register is busy
  logic [15:0]     res_data_q, res_data_d;
  logic            res_scr_q, res_scr_d;

  logic            m_valid_q, m_valid_d;
  logic [27:0]     m_data_q, m_data_d;

  // screen and glyph RAM ports
  logic            scr_we;
  logic [CURW-1:0] scr_waddr, scr_raddr;
  logic [15:0]     scr_wdata, scr_rdata;
  logic            glt_we;
  logic [7:0]      glt_waddr, glt_wdata, glt_raddr, glt_rdata;

  logic            accept;
  logic [15:0]     idx16;
  logic [PW:0]     src;
  logic [15:0]     blank;
  logic            out_free;

  // put-character datapath
  logic [CURW:0]   cur_x, base_x, new_cur, new_base;
  logic [COLW-1:0] new_col;
  logic [COLW:0]   col_t;
  logic [2:0]      tab_delta;

  // finishing strobe and its result
  logic            fin;
  logic [15:0]     fin_data;
  logic            fin_scr;
  logic [15:0]     cur16;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign idx16         = 16'(s_axis_tdata[26:16]);
  assign src           = (PW+1)'(ptr_q) + SRC_OFS;
  assign blank         = {attr_q, GLYPH_SPACE};
  assign out_free      = !m_valid_q || m_axis_tready;

  // screen read: requested cell while idle, line below while scrolling
  assign scr_raddr = (state_q == ST_SCROLL) ? ((src < SRC_LIM) ? CURW'(src) : '0)
                                            : CURW'(idx16);
  assign glt_raddr = s_axis_tdata[7:0];

  tcce_ram #(
    .Width (16),
    .Depth (CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (scr_we),
    .waddr_i (scr_waddr),
    .wdata_i (scr_wdata),
    .raddr_i (scr_raddr),
    .rdata_o (scr_rdata)
  );

  tcce_ram #(
    .Width (8),
    .Depth (GLYPH_DEPTH)
  ) u_glyphs (
    .clk_i   (clk_i),
    .we_i    (glt_we),
    .waddr_i (glt_waddr),
    .wdata_i (glt_wdata),
    .raddr_i (glt_raddr),
    .rdata_o (glt_rdata)
  );

  always_comb begin
    cur_x     = {1'b0, cursor_q};
    base_x    = {1'b0, base_q};
    tab_delta = TAB_STEP - {1'b0, cursor_q[1:0]};
    new_cur   = cur_x;
    new_base  = base_x;
    new_col   = col_q;
    col_t     = '0;

    state_d    = state_q;
    ptr_d      = ptr_q;
    cursor_d   = cursor_q;
    base_d     = base_q;
    col_d      = col_q;
    res_data_d = res_data_q;
    res_scr_d  = res_scr_q;

    scr_we    = 1'b0;
    scr_waddr = cursor_q;
    scr_wdata = blank;
    glt_we    = 1'b0;
    glt_waddr = code_q;
    glt_wdata = glyph_q;

    fin      = 1'b0;
    fin_data = '0;
    fin_scr  = 1'b0;

    case (state_q)
      ST_INIT: begin
        scr_we    = (ptr_q < P_CELLS);
        scr_waddr = CURW'(ptr_q);
        scr_wdata = CELL_RESET;
        glt_we    = (ptr_q < P_GLYPHS);
        glt_waddr = ptr_q[7:0];
        glt_wdata = ptr_q[7:0];
        if (ptr_q == P_INITEND) begin
          state_d = ST_IDLE;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        case (req_q)
          REQ_PUT: begin
            if (code_q == CHAR_NUL) begin
              // ignored
            end else if (code_q == CHAR_BS && cursor_q != '0) begin
              new_cur = cur_x - 1'b1;
              if (col_q == '0) begin
                new_col  = LAST_COL;
                new_base = base_x - COLS_X;
              end else begin
                new_col = col_q - 1'b1;
              end
              scr_we    = 1'b1;
              scr_waddr = CURW'(new_cur);
            end else if (code_q == CHAR_TAB) begin
              new_cur = cur_x + (CURW+1)'(tab_delta);
              col_t   = (COLW+1)'(col_q) + (COLW+1)'(tab_delta);
              if (col_t >= COLS_C) begin
                new_col  = COLW'(col_t - COLS_C);
                new_base = base_x + COLS_X;
              end else begin
                new_col = COLW'(col_t);
              end
            end else if (code_q == CHAR_CR) begin
              new_cur = base_x;
              new_col = '0;
            end else if (code_q == CHAR_LF) begin
              new_base = base_x + COLS_X;
              new_cur  = new_base;
              new_col  = '0;
            end else if (code_q >= GLYPH_SPACE) begin
              scr_we    = 1'b1;
              scr_wdata = {attr_q, glt_rdata};
              new_cur   = cur_x + 1'b1;
              if (col_q == LAST_COL) begin
                new_col  = '0;
                new_base = base_x + COLS_X;
              end else begin
                new_col = col_q + 1'b1;
              end
            end
            if (new_base >= CELLS_X) begin
              // ran off the screen: cursor to start of last line, then scroll
              cursor_d = LAST_ROW;
              base_d   = LAST_ROW;
              col_d    = '0;
              ptr_d    = '0;
              state_d  = ST_SCROLL;
            end else begin
              cursor_d = CURW'(new_cur);
              base_d   = CURW'(new_base);
              col_d    = new_col;
              fin      = 1'b1;
            end
          end
          REQ_CLEAR: begin
            cursor_d = '0;
            base_d   = '0;
            col_d    = '0;
            ptr_d    = '0;
            state_d  = ST_CLEAR;
          end
          REQ_LOAD: begin
            glt_we = 1'b1;
            fin    = 1'b1;
          end
          REQ_READ: begin
            fin      = 1'b1;
            fin_data = inrange_q ? scr_rdata : '0;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end

      ST_SCROLL: begin
        // step k reads cell k+COLUMNS and writes cell k-1 from the previous read
        if (ptr_q != '0) begin
          scr_we    = 1'b1;
          scr_waddr = CURW'(ptr_q - 1'b1);
          scr_wdata = (ptr_q >= P_BLANK) ? blank : scr_rdata;
        end
        if (ptr_q == P_CELLS) begin
          fin     = 1'b1;
          fin_scr = 1'b1;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      ST_CLEAR: begin
        scr_we    = 1'b1;
        scr_waddr = CURW'(ptr_q);
        if (ptr_q == P_LASTC) begin
          fin = 1'b1;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (fin) begin
      if (out_free) begin
        state_d = ST_IDLE;
      end else begin
        res_data_d = fin_data;
        res_scr_d  = fin_scr;
        state_d    = ST_DONE;
      end
    end
  end

  // output register
  assign cur16 = 16'(cursor_d);

  always_comb begin
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    if (fin && out_free) begin
      m_valid_d = 1'b1;
      m_data_d  = {fin_scr, fin_data, cur16[10:0]};
    end else if (state_q == ST_DONE && out_free) begin
      m_valid_d = 1'b1;
      m_data_d  = {res_scr_q, res_data_q, cur16[10:0]};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0000, m_data_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      ptr_q     <= '0;
      cursor_q  <= '0;
      base_q    <= '0;
      col_q     <= '0;
      attr_q    <= ATTR_RESET;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      cursor_q  <= cursor_d;
      base_q    <= base_d;
      col_q     <= col_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q     <= req_e'(s_axis_tuser);
      code_q    <= s_axis_tdata[7:0];
      glyph_q   <= s_axis_tdata[15:8];
      inrange_q <= (idx16 < IDX_LIM);
    end
    res_data_q <= res_data_d;
    res_scr_q  <= res_scr_d;
    m_data_q   <= m_data_d;
  end

  // cursor is always the line start plus the column
  a_cursor_split : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q == base_q + CURW'(col_q))
    else $error("cursor out of step with line start and column");

  // column never reaches the line width
  a_col_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (COLW+1)'(col_q) < COLS_C)
    else $error("column beyond line width");

  // an accepted item is executed in the following cycle
  a_accept_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_EXEC)
    else $error("accepted item not executed");

  // a scrolling result always leaves the cursor at the start of the last line
  a_scroll_cursor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin && fin_scr) |-> cursor_q == LAST_ROW)
    else $error("scroll finished with cursor off the last line");

endmodule

### test/tb_text_console_cursor_engine_top.sv
`timescale 1ns / 100ps

module tb_text_console_cursor_engine_top;
  import tcce_pkg::*;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int CELLS       = COLUMNS * ROWS;
  // longest legal quiet stretch is a clear or scroll pass plus a long receiver hold-off
  localparam int STALL_LIMIT = 20000;
  localparam int HOLDOFF_LEN = 300;

  // one result item, split into its fields
  typedef struct packed {
    logic [10:0] cursor;
    logic [15:0] read_data;
    logic        scrolled;
  } console_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [7:0]  cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;   // char_code[7:0], glyph_value[15:8], cell_index[26:16]
  logic [1:0]  s_axis_tuser  = '0;   // req_type[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // cursor_pos[10:0], read_data[26:11], scrolled[27]

  // shadow copy of the console state, updated on every accepted item
  logic [15:0] shadow_screen [CELLS];
  logic [7:0]  shadow_glyph  [GLYPH_DEPTH];
  logic [7:0]  shadow_attr;
  int unsigned shadow_cursor;

  console_result_t pending_results [$];
  int error_count  = 0;
  int quiet_cycles = 0;
  int holdoff_len  = 0;   // set by the stimulus, consumed by the receiver
  bit tx_steady    = 1'b0;
  bit rx_steady    = 1'b0;

  text_console_cursor_engine_top #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // console predictor
  // ---------------------------------------------------------------------------

  // blank cells use the attribute in force when they are blanked
  function automatic void blank_cells(int from, int count);
    for (int k = from; k < from + count && k < CELLS; k++)
      shadow_screen[k] = {shadow_attr, GLYPH_SPACE};
  endfunction

  function automatic void reset_shadow();
    shadow_attr   = ATTR_RESET;
    shadow_cursor = 0;
    for (int k = 0; k < GLYPH_DEPTH; k++)
      shadow_glyph[k] = 8'(k);
    blank_cells(0, CELLS);
  endfunction

  // cursor past the last cell: move every line up, blank the last one
  function automatic bit scroll_shadow();
    if (shadow_cursor < CELLS)
      return 1'b0;
    for (int k = 0; k < CELLS - COLUMNS; k++)
      shadow_screen[k] = shadow_screen[k + COLUMNS];
    blank_cells(CELLS - COLUMNS, COLUMNS);
    shadow_cursor = CELLS - COLUMNS;
    return 1'b1;
  endfunction

  function automatic bit put_shadow(logic [7:0] c);
    if (c == CHAR_NUL)
      return 1'b0;
    if (c == CHAR_BS && shadow_cursor != 0) begin
      shadow_cursor--;
      shadow_screen[shadow_cursor] = {shadow_attr, GLYPH_SPACE};
    end else if (c == CHAR_TAB) begin
      shadow_cursor = (shadow_cursor + TAB_STEP) & ~(int'(TAB_STEP) - 1);
    end else if (c == CHAR_CR) begin
      shadow_cursor = (shadow_cursor / COLUMNS) * COLUMNS;
    end else if (c == CHAR_LF) begin
      shadow_cursor = ((shadow_cursor + COLUMNS) / COLUMNS) * COLUMNS;
    end else if (c >= GLYPH_SPACE) begin
      shadow_screen[shadow_cursor] = {shadow_attr, shadow_glyph[c]};
      shadow_cursor++;
    end
    return scroll_shadow();
  endfunction

  function automatic console_result_t console_apply(req_e req, logic [7:0] code,
                                                    logic [7:0] glyph, logic [10:0] addr);
    console_result_t r;
    r = '0;
    case (req)
      REQ_PUT:   r.scrolled = put_shadow(code);
      REQ_CLEAR: begin
        shadow_cursor = 0;
        blank_cells(0, CELLS);
      end
      REQ_LOAD:  shadow_glyph[code] = glyph;
      default:   if (addr < CELLS) r.read_data = shadow_screen[addr];
    endcase
    r.cursor = shadow_cursor[10:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: attribute writes, result check, then prediction of accepted items
  // ---------------------------------------------------------------------------

  task automatic report(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    console_result_t want;
    console_result_t got;
    if (rst_ni) begin
      if (cfg_we_i)
        shadow_attr = cfg_wdata_i;
      if (m_axis_tvalid && m_axis_tready) begin
        got.cursor    = m_axis_tdata[10:0];
        got.read_data = m_axis_tdata[26:11];
        got.scrolled  = m_axis_tdata[27];
        if (pending_results.size() == 0) begin
          report($sformatf("result item %h with no request pending", m_axis_tdata));
        end else begin
          want = pending_results.pop_front();
          if (got.cursor !== want.cursor)
            report($sformatf("cursor_pos expected %0d got %0d", want.cursor, got.cursor));
          if (got.read_data !== want.read_data)
            report($sformatf("read_data expected %h got %h", want.read_data, got.read_data));
          if (got.scrolled !== want.scrolled)
            report($sformatf("scrolled expected %b got %b", want.scrolled, got.scrolled));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        pending_results.push_back(console_apply(req_e'(s_axis_tuser), s_axis_tdata[7:0],
                                                s_axis_tdata[15:8], s_axis_tdata[26:16]));
    end
  end

  // watchdog: too long with no handshake on either side ends the run
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // idling on both sides
  // ---------------------------------------------------------------------------

  // mostly back to back, some short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // result receiver: random stalls, steady stretches, and one long hold-off on request
  always begin
    int stall;
    @(negedge clk_i);
    if (holdoff_len != 0) begin
      m_axis_tready <= 1'b0;
      repeat (holdoff_len) @(negedge clk_i);
      holdoff_len = 0;
    end else if (rx_steady) begin
      m_axis_tready <= 1'b1;
    end else begin
      stall = gap_len();
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus tasks, called at a falling edge
  // ---------------------------------------------------------------------------

  // valid stays high on return so the next item can follow without a gap
  task automatic send_item(req_e req, logic [7:0] code, logic [7:0] glyph, logic [10:0] addr);
    int gap;
    gap = tx_steady ? 0 : gap_len();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {5'b0, addr, glyph, code};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // unused fields carry random junk
  task automatic put_char(logic [7:0] c);
    send_item(REQ_PUT, c, 8'($urandom), 11'($urandom));
  endtask

  task automatic read_cell(logic [10:0] addr);
    send_item(REQ_READ, 8'($urandom), 8'($urandom), addr);
  endtask

  task automatic load_glyph(logic [7:0] code, logic [7:0] glyph);
    send_item(REQ_LOAD, code, glyph, 11'($urandom));
  endtask

  task automatic clear_screen();
    send_item(REQ_CLEAR, 8'($urandom), 8'($urandom), 11'($urandom));
  endtask

  // sender pause until every expected result is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // attribute changes only with the block idle
  task automatic write_attribute(logic [7:0] value);
    drain();
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'($urandom_range(GLYPH_SPACE, 255));
    if (r < 80) return CHAR_LF;
    if (r < 85) return CHAR_CR;
    if (r < 90) return CHAR_TAB;
    if (r < 95) return CHAR_BS;
    if (r < 97) return CHAR_NUL;
    return 8'($urandom_range(1, GLYPH_SPACE - 1));
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // edges of every field, each control code, each request kind
  task automatic test_directed();
    read_cell(11'd0);
    read_cell(11'(CELLS - 1));
    read_cell(11'(CELLS));          // just past the screen reads zero
    read_cell(11'h7FF);
    put_char(CHAR_NUL);
    put_char(CHAR_BS);              // backspace at cursor zero does nothing
    put_char(8'h41);
    put_char(GLYPH_SPACE);
    put_char(8'h7F);
    put_char(8'hFF);
    put_char(CHAR_BS);              // backspace with cursor above zero blanks a cell
    put_char(8'h01);
    put_char(8'h1F);
    put_char(CHAR_TAB);
    put_char(CHAR_CR);
    put_char(CHAR_LF);
    load_glyph(8'h41, 8'h00);
    put_char(8'h41);                // translated through the loaded entry
    load_glyph(8'h41, 8'h41);
    load_glyph(8'hFF, 8'hFF);
    read_cell(11'd80);
    read_cell(11'd2);
    clear_screen();
    read_cell(11'd0);
  endtask

  // extreme and mid attribute values on written, erased and cleared cells
  task automatic test_attribute();
    logic [7:0] values [4];
    values = '{8'h00, 8'hFF, 8'hA5, 8'h5A};
    foreach (values[i]) begin
      write_attribute(values[i]);
      repeat (3) put_char(8'($urandom_range(GLYPH_SPACE, 255)));
      put_char(CHAR_BS);
      read_cell(11'(shadow_cursor - 1));
      read_cell(11'(shadow_cursor));
      clear_screen();
      read_cell(11'd0);
      read_cell(11'(CELLS - 1));
    end
  endtask

  // walk the cursor to the last line, then run off the end by text, tab or line feed
  task automatic test_scroll();
    for (int round = 0; round < 6; round++) begin
      while (shadow_cursor < CELLS - COLUMNS) begin
        if ($urandom_range(0, 3) == 0)
          put_char(8'($urandom_range(GLYPH_SPACE, 255)));
        else
          put_char(CHAR_LF);
      end
      case (round % 3)
        0: repeat (CELLS - shadow_cursor) put_char(8'($urandom_range(GLYPH_SPACE, 255)));
        1: while (shadow_cursor >= CELLS - COLUMNS && shadow_cursor != CELLS - COLUMNS
                  || shadow_cursor == CELLS - COLUMNS && round != 99) begin
          put_char(CHAR_TAB);
          if (shadow_cursor == CELLS - COLUMNS) break;
        end
        default: put_char(CHAR_LF);
      endcase
      put_char(CHAR_BS);
      read_cell(11'(CELLS - COLUMNS - 1 - $urandom_range(0, COLUMNS - 1)));
      read_cell(11'(CELLS - 1));
    end
  endtask

  // receiver holds off while the sender keeps offering, then the sender waits it out
  task automatic test_backpressure();
    drain();
    holdoff_len = HOLDOFF_LEN;
    tx_steady   = 1'b1;
    repeat (40) put_char(pick_char());
    tx_steady = 1'b0;
    drain();
  endtask

  // mixed traffic in phases, each opening with an attribute write; one phase has a steady sender, one a steady receiver
  task automatic test_random();
    int r;
    for (int phase = 0; phase < 4; phase++) begin
      write_attribute(phase == 0 ? 8'h00 : phase == 1 ? 8'hFF : 8'($urandom));
      tx_steady = (phase == 1);
      rx_steady = (phase == 2);
      repeat (300) begin
        r = $urandom_range(0, 99);
        if (r < 78) begin
          put_char(pick_char());
        end else if (r < 90) begin
          r = $urandom_range(0, 9);
          if (r == 0)
            read_cell(11'($urandom_range(CELLS, 2047)));
          else if (r == 1)
            read_cell(11'(shadow_cursor == 0 ? 0 : shadow_cursor - 1));
          else
            read_cell(11'($urandom_range(0, CELLS - 1)));
        end else if (r < 98) begin
          load_glyph(8'($urandom), 8'($urandom));
        end else begin
          clear_screen();
        end
        if ($urandom_range(0, 99) == 0)
          drain();
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------

  initial begin
    reset_shadow();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_attribute();
    test_scroll();
    test_backpressure();
    test_random();

    drain();
    repeat (50) @(negedge clk_i);
    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
